/* src/rgb2ycc_pkg.sv */
// Shared types and constants of the RGB to YCbCr 4:2:0 encoder.
`default_nettype none

package rgb2ycc_pkg;

  // Configuration register indexes and port widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Coordinates inside the block are wide enough for the largest supported frame.
  localparam int COORD_W = 13;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Video-range limits.
  localparam logic [8:0] LUMA_MIN   = 9'd16;
  localparam logic [8:0] LUMA_MAX   = 9'd235;
  localparam logic [8:0] CHROMA_MIN = 9'd16;
  localparam logic [8:0] CHROMA_MAX = 9'd240;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0]  luma;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic        chroma_valid;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
    logic        frame_end;
  } pixel_out_t;

  // Component sums of one horizontal pixel pair.
  typedef struct packed {
    logic [8:0] sum_b;
    logic [8:0] sum_g;
    logic [8:0] sum_r;
  } pair_sum_t;

  // One classified pixel, passed from the front part to the back part.
  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               pair;       // odd column: a horizontal pair is complete
    logic               odd_row;
    pair_sum_t          sums;
    logic               frame_end;
  } cmd_t;

  // Position and flags that ride along the back pipeline.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               chroma;
    logic               frame_end;
  } tag_t;

endpackage

`default_nettype wire

/* src/rgb2ycc_front.sv */
// Front part: frame configuration, raster counters, left pixel and pair sums.
`default_nettype none

module rgb2ycc_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_write,
  input  wire [rgb2ycc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [rgb2ycc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                                 accept,
  input  rgb2ycc_pkg::pixel_in_t              pixel,
  output rgb2ycc_pkg::cmd_t                   cmd
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = (CW + 1 > rgb2ycc_pkg::CFG_DATA_W) ? CW + 1 : rgb2ycc_pkg::CFG_DATA_W;
  localparam int HW = (RW + 1 > rgb2ycc_pkg::CFG_DATA_W) ? RW + 1 : rgb2ycc_pkg::CFG_DATA_W;
  localparam int W_RESET = (2048 > MAX_WIDTH) ? MAX_WIDTH : 2048;
  localparam int H_RESET = (2048 > MAX_HEIGHT) ? MAX_HEIGHT : 2048;

  logic [SW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic [CW-1:0] x;
  logic [RW-1:0] y;
  rgb2ycc_pkg::pixel_in_t left;
  logic row_end;
  logic last_row;

  // Sizes are stored already clamped to 1..MAX.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= SW'(W_RESET);
      height_eff <= HW'(H_RESET);
    end else if (cfg_write) begin
      if (cfg_index == rgb2ycc_pkg::REG_FRAME_WIDTH) begin
        if (cfg_data == '0) begin
          width_eff <= SW'(1);
        end else if (SW'(cfg_data) > SW'(MAX_WIDTH)) begin
          width_eff <= SW'(MAX_WIDTH);
        end else begin
          width_eff <= SW'(cfg_data);
        end
      end else if (cfg_index == rgb2ycc_pkg::REG_FRAME_HEIGHT) begin
        if (cfg_data == '0) begin
          height_eff <= HW'(1);
        end else if (HW'(cfg_data) > HW'(MAX_HEIGHT)) begin
          height_eff <= HW'(MAX_HEIGHT);
        end else begin
          height_eff <= HW'(cfg_data);
        end
      end
    end
  end

  assign row_end  = (SW'(x) + SW'(1)) >= width_eff;
  assign last_row = (HW'(y) + HW'(1)) >= height_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      x    <= '0;
      y    <= '0;
      left <= '0;
    end else if (accept) begin
      if (!x[0]) begin
        left <= pixel;
      end
      if (row_end) begin
        x <= '0;
        if (last_row) begin
          y <= '0;
        end else begin
          y <= y + RW'(1);
        end
      end else begin
        x <= x + CW'(1);
      end
    end
  end

  always_comb begin
    cmd.red        = pixel.red;
    cmd.green      = pixel.green;
    cmd.blue       = pixel.blue;
    cmd.x          = rgb2ycc_pkg::COORD_W'(x);
    cmd.y          = rgb2ycc_pkg::COORD_W'(y);
    cmd.pair       = x[0];
    cmd.odd_row    = y[0];
    cmd.sums.sum_r = 9'(left.red) + 9'(pixel.red);
    cmd.sums.sum_g = 9'(left.green) + 9'(pixel.green);
    cmd.sums.sum_b = 9'(left.blue) + 9'(pixel.blue);
    cmd.frame_end  = row_end && last_row;
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.frame_end |=> x == '0 && y == '0)
    else $error("counters did not return to the origin after the last pixel");

  a_left_capture: assert property (@(posedge clk) disable iff (rst)
    accept && !x[0] |=> left == $past(pixel))
    else $error("left pixel not captured at an even column");

endmodule

`default_nettype wire

/* src/rgb2ycc_queue.sv */
// Short queue of classified pixels between the front and back parts.
`default_nettype none

module rgb2ycc_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  rgb2ycc_pkg::cmd_t  push_cmd,
  output logic               full,
  input  wire                pop,
  output logic               head_valid,
  output rgb2ycc_pkg::cmd_t  head
);

  localparam int DEPTH = rgb2ycc_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  rgb2ycc_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full       = count == NW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("word pushed into a full queue");

  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + NW'(1))
    else $error("queue fill level did not grow on a push");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - NW'(1))
    else $error("queue fill level did not shrink on a pop");

endmodule

`default_nettype wire

/* src/rgb2ycc_back.sv */
// Back part: line store, luma, 2x2 averaging, chroma and the output register.
`default_nettype none

module rgb2ycc_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       head_valid,
  input  rgb2ycc_pkg::cmd_t         head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire                       out_ready,
  output rgb2ycc_pkg::pixel_out_t   out_word
);

  localparam int DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = rgb2ycc_pkg::COORD_W;

  // Even-row pair sums, one entry per chroma column.
  rgb2ycc_pkg::pair_sum_t store [DEPTH];

  logic adv;
  logic [IW-1:0] idx;

  // Stage A: store access.
  logic                     a_valid;
  rgb2ycc_pkg::cmd_t        a_cmd;
  rgb2ycc_pkg::pair_sum_t   a_above;

  // Stage B: luma and block averages.
  logic                     b_valid;
  rgb2ycc_pkg::tag_t        b_tag;
  logic [7:0]               b_luma;
  logic [7:0]               b_avg_r;
  logic [7:0]               b_avg_g;
  logic [7:0]               b_avg_b;

  // Stage C: offset chroma sums.
  logic                     c_valid;
  rgb2ycc_pkg::tag_t        c_tag;
  logic [7:0]               c_luma;
  logic [16:0]              c_cb;
  logic [16:0]              c_cr;

  // Stage D: output register.
  logic                     d_valid;

  logic [15:0] luma_sum;
  logic [8:0]  luma_raw;
  logic [9:0]  sum4_r;
  logic [9:0]  sum4_g;
  logic [9:0]  sum4_b;
  logic [8:0]  cb_raw;
  logic [8:0]  cr_raw;
  logic [7:0]  cb_clamped;
  logic [7:0]  cr_clamped;

  // The whole pipeline moves together; it freezes only while a result waits.
  assign adv       = !d_valid || out_ready;
  assign pop       = head_valid && adv;
  assign out_valid = d_valid;
  assign idx       = IW'(head.x[CW-1:1]);

  always_ff @(posedge clk) begin
    if (pop && head.pair && !head.odd_row) begin
      store[idx] <= head.sums;
    end
    if (pop && head.pair && head.odd_row) begin
      a_above <= store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= head_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_comb begin
    luma_sum = 16'd47 * 16'(a_cmd.red) + 16'd157 * 16'(a_cmd.green)
             + 16'd16 * 16'(a_cmd.blue) + 16'd128;
    luma_raw = rgb2ycc_pkg::LUMA_MIN + 9'(luma_sum[15:8]);
    sum4_r   = 10'(a_cmd.sums.sum_r) + 10'(a_above.sum_r) + 10'd2;
    sum4_g   = 10'(a_cmd.sums.sum_g) + 10'(a_above.sum_g) + 10'd2;
    sum4_b   = 10'(a_cmd.sums.sum_b) + 10'(a_above.sum_b) + 10'd2;
  end

  always_comb begin
    cb_raw = c_cb[16:8];
    cr_raw = c_cr[16:8];
    if (cb_raw < rgb2ycc_pkg::CHROMA_MIN) begin
      cb_clamped = 8'(rgb2ycc_pkg::CHROMA_MIN);
    end else if (cb_raw > rgb2ycc_pkg::CHROMA_MAX) begin
      cb_clamped = 8'(rgb2ycc_pkg::CHROMA_MAX);
    end else begin
      cb_clamped = 8'(cb_raw);
    end
    if (cr_raw < rgb2ycc_pkg::CHROMA_MIN) begin
      cr_clamped = 8'(rgb2ycc_pkg::CHROMA_MIN);
    end else if (cr_raw > rgb2ycc_pkg::CHROMA_MAX) begin
      cr_clamped = 8'(rgb2ycc_pkg::CHROMA_MAX);
    end else begin
      cr_clamped = 8'(cr_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd <= head;

      b_tag.x         <= a_cmd.x;
      b_tag.y         <= a_cmd.y;
      b_tag.chroma    <= a_cmd.pair && a_cmd.odd_row;
      b_tag.frame_end <= a_cmd.frame_end;
      if (luma_raw > rgb2ycc_pkg::LUMA_MAX) begin
        b_luma <= 8'(rgb2ycc_pkg::LUMA_MAX);
      end else if (luma_raw < rgb2ycc_pkg::LUMA_MIN) begin
        b_luma <= 8'(rgb2ycc_pkg::LUMA_MIN);
      end else begin
        b_luma <= 8'(luma_raw);
      end
      b_avg_r <= sum4_r[9:2];
      b_avg_g <= sum4_g[9:2];
      b_avg_b <= sum4_b[9:2];

      // 128 + round(t / 256): t is offset by 32768 + 128 so the sum stays positive and rounds.
      c_tag  <= b_tag;
      c_luma <= b_luma;
      c_cb   <= 17'd32896 + 17'd113 * 17'(b_avg_b)
              - 17'd26 * 17'(b_avg_r) - 17'd87 * 17'(b_avg_g);
      c_cr   <= 17'd32896 + 17'd112 * 17'(b_avg_r)
              - 17'd94 * 17'(b_avg_g) - 17'd18 * 17'(b_avg_b);

      out_word.luma         <= c_luma;
      out_word.pixel_x      <= 11'(c_tag.x);
      out_word.pixel_y      <= 11'(c_tag.y);
      out_word.chroma_valid <= c_tag.chroma;
      out_word.chroma_blue  <= c_tag.chroma ? cb_clamped : 8'd0;
      out_word.chroma_red   <= c_tag.chroma ? cr_clamped : 8'd0;
      out_word.frame_end    <= c_tag.frame_end;
    end
  end

  a_chroma_at_odd_odd: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.chroma_valid |-> out_word.pixel_x[0] && out_word.pixel_y[0])
    else $error("chroma given outside an odd column of an odd row");

  a_no_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.chroma_valid |->
      out_word.chroma_blue == 8'd0 && out_word.chroma_red == 8'd0)
    else $error("chroma fields not zero on a luma-only word");

  // Only occupied stages carry meaningful words; empty ones may hold anything.
  a_pipe_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> (!a_valid || $stable(a_cmd)) && (!b_valid || $stable(b_tag)) &&
      (!c_valid || $stable(c_tag)) && a_valid == $past(a_valid))
    else $error("pipeline stage moved while the output was stalled");

endmodule

`default_nettype wire

/* src/rgb_to_ycbcr420_encoder_top.sv */
// Top level of the RGB to video-range YCbCr 4:2:0 encoder (BT.709 luma and Cb weights, BT.601 Cr weights).
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+----------------------------------
// pixel in  | input     | in_valid / in_ready    | in_word  (red, green, blue)
// result    | output    | out_valid / out_ready  | out_word (luma, pixel_x, pixel_y,
//           |           |                        |   chroma_valid, chroma_blue,
//           |           |                        |   chroma_red, frame_end)
// config    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One pixel word is accepted per clock while the queue has room, and one result word leaves
// per clock while out_ready is high. An accepted pixel goes into the queue, then through
// the store-access, luma/average, chroma and output stages. The line store takes one write
// or one registered read per pixel pair, at its odd column.
// Reset (rst, synchronous) clears the counters, the left pixel and all valid state and
// loads both sizes with 2048 (or the maximum if smaller); the line store is not cleared.
// While a result waits, the back pipeline freezes and the four-word queue keeps taking
// pixels; in_ready drops only in reset or when the queue is full.

module rgb_to_ycbcr420_encoder_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire                                 clk,
  input  wire                                 rst,

  input  wire                                 in_valid,
  output logic                                in_ready,
  input  rgb2ycc_pkg::pixel_in_t              in_word,

  output logic                                out_valid,
  input  wire                                 out_ready,
  output rgb2ycc_pkg::pixel_out_t             out_word,

  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [rgb2ycc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [rgb2ycc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic              accept;
  logic              cfg_write;
  logic              queue_full;
  logic              head_valid;
  logic              pop;
  rgb2ycc_pkg::cmd_t cmd;
  rgb2ycc_pkg::cmd_t head;

  // Configuration writes are taken on any cycle outside reset; the sizes apply at once.
  assign cfg_ready = !rst;
  assign cfg_write = cfg_valid && cfg_ready;

  // A pixel word is taken whenever the queue has room outside reset; the front part classifies it
  // in the same cycle and the classified word goes straight into the queue.
  assign in_ready = !rst && !queue_full;
  assign accept   = in_valid && in_ready;

  rgb2ycc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pixel     (in_word),
    .cmd       (cmd)
  );

  rgb2ycc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_cmd   (cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back part owns the line store: even rows write pair sums, odd rows read them
  // back to close each 2x2 block.
  rgb2ycc_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire
